>>> hw/rtl/mmh_pkg.sv
// Shared types and constants for the MurmurHash64A block.
// Depends on nothing; every other file of the block imports it.
package mmh_pkg;

    localparam int WordW    = 64;
    localparam int LenW     = 32;
    localparam int NbW      = 4;
    localparam int HalfW    = 32;
    localparam int PaddrW   = 4;
    localparam int CmdDepth = 4;
    localparam int CmdPtrW  = $clog2(CmdDepth);
    localparam int CmdCntW  = $clog2(CmdDepth + 1);

    localparam logic [WordW-1:0] MixMul    = 64'hc6a4a7935bd1e995;
    localparam int               MixShift  = 47;
    localparam logic [WordW-1:0] SeedReset = 64'd1000;

    // Register map: bit 3 of the byte address selects the 64-bit register.
    localparam logic SeedRegSel = 1'b0;

    // One classified word on its way from the front end to the back end.
    typedef struct packed {
        logic             first;
        logic             full;
        logic             tail;
        logic             last;
        logic [LenW-1:0]  msg_length;
        logic [WordW-1:0] word;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_K1,
        S_K2,
        S_HMUL,
        S_FIN,
        S_OUT
    } t_bstate;

    // Mask that keeps the low nb bytes of a partial word.
    function automatic logic [WordW-1:0] tail_mask(input logic [2:0] nb);
        logic [WordW-1:0] m;
        m = '0;
        unique case (nb)
            3'd0:    m = 64'h0000_0000_0000_0000;
            3'd1:    m = 64'h0000_0000_0000_00ff;
            3'd2:    m = 64'h0000_0000_0000_ffff;
            3'd3:    m = 64'h0000_0000_00ff_ffff;
            3'd4:    m = 64'h0000_0000_ffff_ffff;
            3'd5:    m = 64'h0000_00ff_ffff_ffff;
            3'd6:    m = 64'h0000_ffff_ffff_ffff;
            3'd7:    m = 64'h00ff_ffff_ffff_ffff;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/mmh_in_if.sv
// Input channel of the hash block: one message word per handshake.
// Depends on mmh_pkg for the field widths.
interface mmh_in_if;
    logic                       valid;
    logic                       ready;
    logic [mmh_pkg::WordW-1:0]  data_word;
    logic [mmh_pkg::NbW-1:0]    valid_bytes;
    logic                       first;
    logic [mmh_pkg::LenW-1:0]   msg_length;
    logic                       last;

    modport source (output valid, data_word, valid_bytes, first, msg_length, last,
                    input ready);
    modport sink   (input valid, data_word, valid_bytes, first, msg_length, last,
                    output ready);
endinterface

>>> hw/rtl/mmh_out_if.sv
// Output channel of the hash block: one finished hash per handshake.
// Depends on mmh_pkg for the field width.
interface mmh_out_if;
    logic                       valid;
    logic                       ready;
    logic [mmh_pkg::WordW-1:0]  hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

>>> hw/rtl/mmh_front.sv
// Front end: accepts input words and classifies them into back-end commands.
// Depends on mmh_pkg and mmh_in_if.
module mmh_front (
    mmh_in_if.sink              i_in,
    input  logic                i_q_full,
    output logic                o_push,
    output mmh_pkg::t_cmd       o_cmd
);
    import mmh_pkg::*;

    logic w_full;
    logic w_tail;

    // Counts of eight and above give a full word.
    assign w_full = i_in.valid_bytes[NbW-1];
    assign w_tail = i_in.last && !w_full && (i_in.valid_bytes[2:0] != 3'd0);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd.first      = i_in.first;
        o_cmd.full       = w_full;
        o_cmd.tail       = w_tail;
        o_cmd.last       = i_in.last;
        o_cmd.msg_length = i_in.msg_length;
        o_cmd.word       = w_full ? i_in.data_word
                                  : (i_in.data_word & tail_mask(i_in.valid_bytes[2:0]));
    end

endmodule

>>> hw/rtl/mmh_fifo.sv
// Short command queue between the front end and the back end.
// Depends on mmh_pkg for the command type and depth.
module mmh_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mmh_pkg::t_cmd       i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output mmh_pkg::t_cmd       o_cmd
);
    import mmh_pkg::*;

    t_cmd               r_mem [CmdDepth];
    logic [CmdPtrW-1:0] r_wptr;
    logic [CmdPtrW-1:0] r_rptr;
    logic [CmdCntW-1:0] r_count;

    assign o_full  = (r_count == CmdCntW'(CmdDepth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/mmh_mul.sv
// Multiplies a 64-bit operand by the mixing constant, keeping the low 64 bits.
// One 32x32 multiplier is used over three passes. Depends on mmh_pkg.
module mmh_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [mmh_pkg::WordW-1:0] i_a,
    output logic                    o_done,
    output logic [mmh_pkg::WordW-1:0] o_p
);
    import mmh_pkg::*;

    logic [WordW-1:0] r_a;
    logic [WordW-1:0] r_acc;
    logic [1:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [HalfW-1:0] w_x;
    logic [HalfW-1:0] w_y;
    logic [WordW-1:0] w_prod;

    // Pass 0: low x low; passes 1 and 2 add the cross terms into the top half.
    always_comb begin
        w_x = r_a[HalfW-1:0];
        w_y = MixMul[HalfW-1:0];
        unique case (r_cnt)
            2'd1:    w_x = r_a[WordW-1:HalfW];
            2'd2:    w_y = MixMul[WordW-1:HalfW];
            default: ;
        endcase
    end

    assign w_prod = WordW'(w_x) * WordW'(w_y);

    assign o_done = r_done;
    assign o_p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
        end
        if (r_busy) begin
            if (r_cnt == 2'd0) begin
                r_acc <= w_prod;
            end else begin
                r_acc <= {r_acc[WordW-1:HalfW] + w_prod[HalfW-1:0], r_acc[HalfW-1:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/mmh_back.sv
// Back end: sequences the hash recurrence for each queued command and holds
// the result register. Depends on mmh_pkg, mmh_mul and mmh_out_if.
module mmh_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [mmh_pkg::WordW-1:0] i_seed,
    input  logic                    i_q_valid,
    input  mmh_pkg::t_cmd           i_q_cmd,
    output logic                    o_pop,
    mmh_out_if.source               o_out
);
    import mmh_pkg::*;

    t_bstate          r_state;
    t_bstate          n_state;
    t_cmd             r_cmd;
    logic [WordW-1:0] r_h;
    logic [WordW-1:0] r_k;
    logic             r_wait;
    logic [WordW-1:0] r_out;
    logic             r_oval;

    logic             w_start;
    logic [WordW-1:0] w_a;
    logic             w_done;
    logic [WordW-1:0] w_p;
    logic             w_out_free;

    // Work that follows once the hash has been (re)started.
    function automatic t_bstate after_start(input t_cmd c);
        t_bstate s;
        priority if (c.full) begin
            s = S_K1;
        end else if (c.tail) begin
            s = S_HMUL;
        end else if (c.last) begin
            s = S_FIN;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    mmh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .o_done  (w_done),
        .o_p     (w_p)
    );

    assign w_out_free = !r_oval || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_cmd.first ? S_LEN : after_start(i_q_cmd);
                end
            end
            S_LEN:  if (w_done) n_state = after_start(r_cmd);
            S_K1:   if (w_done) n_state = S_K2;
            S_K2:   if (w_done) n_state = S_HMUL;
            S_HMUL: if (w_done) n_state = r_cmd.last ? S_FIN : S_IDLE;
            S_FIN:  if (w_done) n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_start = 1'b0;
        w_a     = r_h;
        unique case (r_state)
            S_IDLE: o_pop = i_q_valid;
            S_LEN: begin
                w_start = !r_wait;
                w_a     = WordW'(r_cmd.msg_length);
            end
            S_K1: begin
                w_start = !r_wait;
                w_a     = r_cmd.word;
            end
            S_K2: begin
                w_start = !r_wait;
                w_a     = r_k;
            end
            S_HMUL: begin
                // A partial word is folded in just before its multiply.
                w_start = !r_wait;
                w_a     = r_cmd.tail ? (r_h ^ r_cmd.word) : r_h;
            end
            S_FIN: begin
                w_start = !r_wait;
                w_a     = r_h ^ (r_h >> MixShift);
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_done && r_state == S_K1) begin
            r_k <= w_p ^ (w_p >> MixShift);
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out <= w_p ^ (w_p >> MixShift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_oval  <= 1'b0;
            r_h     <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_wait <= 1'b1;
            end else if (w_done) begin
                r_wait <= 1'b0;
            end
            if (w_done) begin
                unique case (r_state)
                    S_LEN:  r_h <= i_seed ^ w_p;
                    S_K2:   r_h <= r_h ^ w_p;
                    S_HMUL: r_h <= w_p;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && w_out_free) begin
                r_oval <= 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_oval;
    assign o_out.hash_value = r_out;

endmodule

>>> hw/rtl/murmur64a_hash.sv
// MurmurHash64A of a byte message delivered as little-endian 64-bit words,
// with a 64-bit seed register (reset 1000) at byte address 0 of the APB port.
// Words are accepted into a four-entry command queue while the hash engine
// works, so the input side stalls only when the queue is full. Every 64-bit
// product by the mixing constant runs on one shared 32x32 multiplier in three
// passes. A full word takes two products and a multiply of the hash, a partial
// last word one multiply, and the first word of a message adds a multiply of
// the length; the last word adds finalisation before the hash is offered on
// the output, where a result register lets the engine continue on the next
// message while the hash waits to be taken.
// Depends on mmh_pkg, mmh_in_if, mmh_out_if, mmh_front, mmh_fifo, mmh_back.
module murmur64a_hash (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mmh_in_if.sink                    i_in,
    mmh_out_if.source                 o_out,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [mmh_pkg::PaddrW-1:0] i_paddr,
    input  logic [mmh_pkg::WordW-1:0]  i_pwdata,
    output logic [mmh_pkg::WordW-1:0]  o_prdata,
    output logic                      o_pready
);
    import mmh_pkg::*;

    logic [WordW-1:0] r_seed;
    logic             w_push;
    t_cmd             w_push_cmd;
    logic             w_q_full;
    logic             w_pop;
    logic             w_q_valid;
    t_cmd             w_q_cmd;
    logic             w_seed_sel;

    assign o_pready   = 1'b1;
    assign w_seed_sel = (i_paddr[PaddrW-1] == SeedRegSel);
    assign o_prdata   = w_seed_sel ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SeedReset;
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_seed_sel) begin
            r_seed <= i_pwdata;
        end
    end

    mmh_front u_front (
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    mmh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    mmh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed    (r_seed),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule
